// File: rtl/core/srma_pkg.sv
// package: controller states and controller/datapath command and status types
`timescale 1ns / 1ps

package srma_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ACC,
    ST_EMIT
  } state_t;

  localparam int unsigned COL_W = 31;
  localparam int unsigned VAL_W = 32;

  typedef struct packed {
    logic accept_add;
    logic accept_empty;
    logic lookup_read;
    logic insert;
    logic set_ovf;
    logic acc_write;
    logic emit_issue;
    logic row_clear;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic count_zero;
    logic emit_last;
  } status_t;

endpackage

// File: rtl/core/srma_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module srma_ram #(
  parameter int unsigned WIDTH = 63,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/srma_ctrl.sv
// controller: sequences add lookups, accumulation and row emission
`timescale 1ns / 1ps

module srma_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              opcode,
  input  srma_pkg::status_t status,
  output logic              busy,
  output srma_pkg::cmd_t    cmd
);

  srma_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      srma_pkg::ST_IDLE: begin
        if (start) begin
          if (!opcode) begin
            state_next = srma_pkg::ST_LOOKUP;
          end else if (!status.count_zero) begin
            state_next = srma_pkg::ST_EMIT;
          end
        end
      end
      srma_pkg::ST_LOOKUP: begin
        state_next = status.hit ? srma_pkg::ST_ACC : srma_pkg::ST_IDLE;
      end
      srma_pkg::ST_ACC: begin
        state_next = srma_pkg::ST_IDLE;
      end
      srma_pkg::ST_EMIT: begin
        if (status.emit_last) begin
          state_next = srma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      srma_pkg::ST_IDLE: begin
        busy             = 1'b0;
        cmd.accept_add   = start && !opcode;
        cmd.accept_empty = start && opcode && status.count_zero;
      end
      srma_pkg::ST_LOOKUP: begin
        cmd.lookup_read = status.hit;
        cmd.insert      = !status.hit && !status.full;
        cmd.set_ovf     = !status.hit && status.full;
      end
      srma_pkg::ST_ACC: begin
        cmd.acc_write = 1'b1;
      end
      srma_pkg::ST_EMIT: begin
        cmd.emit_issue = 1'b1;
        cmd.row_clear  = status.emit_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/srma_dp.sv
// datapath: column match cells, sum ram, saturating accumulate, result registers
`timescale 1ns / 1ps

module srma_dp #(
  parameter int unsigned ROW_CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  srma_pkg::cmd_t                   cmd,
  input  logic [srma_pkg::COL_W-1:0]       column,
  input  logic signed [srma_pkg::VAL_W-1:0] value,
  output srma_pkg::status_t                status,
  output logic                             strobe,
  output logic [srma_pkg::COL_W-1:0]       column_res,
  output logic signed [srma_pkg::VAL_W-1:0] sum,
  output logic                             last,
  output logic                             empty_row,
  output logic                             overflow
);

  localparam int unsigned IDX_W = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(ROW_CAPACITY + 1);
  localparam int unsigned COL_W = srma_pkg::COL_W;
  localparam int unsigned VAL_W = srma_pkg::VAL_W;
  localparam int unsigned WORD_W = COL_W + VAL_W;

  logic [COL_W-1:0]        cells [ROW_CAPACITY];
  logic [ROW_CAPACITY-1:0] match;
  logic [ROW_CAPACITY-1:0] match_next;
  logic [COL_W-1:0]        col_q;
  logic signed [VAL_W-1:0] val_q;
  logic [CNT_W-1:0]        count;
  logic                    ovf;
  logic [IDX_W-1:0]        emit_idx;
  logic [IDX_W-1:0]        hit_idx;
  logic [IDX_W-1:0]        acc_idx;
  logic                    out_valid;
  logic                    out_last;
  logic                    out_empty;
  logic                    out_ovf;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [WORD_W-1:0]       ram_q;

  logic signed [VAL_W:0]   wide_sum;
  logic signed [VAL_W-1:0] sat_sum;

  // compare the incoming column against every occupied cell
  always_comb begin
    for (int i = 0; i < ROW_CAPACITY; i++) begin
      match_next[i] = (CNT_W'(i) < count) && (cells[i] == column);
    end
  end

  // one-hot to index; distinct columns keep at most one bit set
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ROW_CAPACITY; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    wide_sum = {ram_q[VAL_W-1], ram_q[VAL_W-1:0]} + {val_q[VAL_W-1], val_q};
    if (wide_sum[VAL_W] != wide_sum[VAL_W-1]) begin
      sat_sum = wide_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      sat_sum = wide_sum[VAL_W-1:0];
    end
  end

  always_comb begin
    ram_we    = cmd.insert || cmd.acc_write;
    ram_waddr = cmd.insert ? count[IDX_W-1:0] : acc_idx;
    ram_wdata = cmd.insert ? {col_q, val_q} : {col_q, sat_sum};
    ram_re    = cmd.lookup_read || cmd.emit_issue;
    ram_raddr = cmd.emit_issue ? emit_idx : hit_idx;
  end

  srma_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ROW_CAPACITY),
    .ADDR_W(IDX_W)
  ) u_sum_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .q    (ram_q)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept_add) begin
      col_q <= column;
      val_q <= value;
      match <= match_next;
    end
    if (cmd.lookup_read) begin
      acc_idx <= hit_idx;
    end
    if (cmd.insert) begin
      cells[count[IDX_W-1:0]] <= col_q;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      out_empty <= 1'b0;
      out_ovf   <= 1'b0;
    end else begin
      out_valid <= cmd.emit_issue || cmd.accept_empty;
      out_last  <= cmd.emit_issue && status.emit_last;
      out_empty <= cmd.accept_empty;
      out_ovf   <= cmd.emit_issue && ovf;
      if (cmd.insert) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.emit_issue) begin
        emit_idx <= emit_idx + IDX_W'(1);
      end
      if (cmd.row_clear) begin
        count    <= '0;
        ovf      <= 1'b0;
        emit_idx <= '0;
      end
    end
  end

  always_comb begin
    status.hit        = |match;
    status.full       = (count == CNT_W'(ROW_CAPACITY));
    status.count_zero = (count == '0);
    status.emit_last  = (CNT_W'(emit_idx) == count - CNT_W'(1));
  end

  assign strobe     = out_valid;
  assign column_res = out_empty ? '0 : ram_q[WORD_W-1:VAL_W];
  assign sum        = out_empty ? '0 : ram_q[VAL_W-1:0];
  assign last       = out_last;
  assign empty_row  = out_empty;
  assign overflow   = out_ovf;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ROW_CAPACITY))
    else $error("fill count above row capacity");

  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup_read |-> $onehot0(match))
    else $error("column matched more than one cell");

  a_row_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_last || out_empty)) |-> (count == '0) && !ovf)
    else $error("row state not cleared after final result");

  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_issue && !status.emit_last) |=> cmd.emit_issue && out_valid && !out_last)
    else $error("row emission broke off early");
`endif

endmodule

// File: rtl/core/sparse_row_merge_accumulate_unit.sv
// top level: sparse row merge accumulator, controller plus datapath
// add word: busy in lookup for a new column, also in acc on a hit (ram read-modify-write)
// close word, n entries: n results read from the ram, one per cycle, busy while emitting
// close word on an empty row: single result the next cycle, block stays ready
// results cannot be stalled; each strobe lasts one cycle and must be taken
// synchronous reset clears the fill count, overflow flag and fsm; tables are not cleared
`timescale 1ns / 1ps

module sparse_row_merge_accumulate_unit #(
  parameter int unsigned ROW_CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode,
  input  logic [srma_pkg::COL_W-1:0]        column,
  input  logic signed [srma_pkg::VAL_W-1:0] value,
  output logic                              strobe,
  output logic [srma_pkg::COL_W-1:0]        column_res,
  output logic signed [srma_pkg::VAL_W-1:0] sum,
  output logic                              last,
  output logic                              empty_row,
  output logic                              overflow
);

  // command and status between the fsm and the datapath
  srma_pkg::cmd_t    cmd;
  srma_pkg::status_t status;

  // fsm: idle accepts words, lookup resolves hit, new entry or overflow,
  // acc writes the saturated sum back, emit walks the table in fill order
  srma_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .opcode(opcode),
    .status(status),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath: match cells compare the column on acceptance,
  // the ram holds column and running sum per entry
  srma_dp #(
    .ROW_CAPACITY(ROW_CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .column    (column),
    .value     (value),
    .status    (status),
    .strobe    (strobe),
    .column_res(column_res),
    .sum       (sum),
    .last      (last),
    .empty_row (empty_row),
    .overflow  (overflow)
  );

endmodule
